FILE: hdl/hgbm_pkg.sv
package hgbm_pkg;

  localparam int CLASS_CAPACITY = 1024;
  localparam int SLOT_COUNT     = 2048;
  localparam int KEY_BYTES      = 8;
  localparam int MAX_ITEMS      = 65536;

  localparam int CLS_W   = $clog2(CLASS_CAPACITY);
  localparam int USED_W  = CLS_W + 1;
  localparam int SLOT_W  = $clog2(SLOT_COUNT);
  localparam int PROBE_W = SLOT_W + 1;
  localparam int SEQ_W   = $clog2(MAX_ITEMS);
  localparam int HASH_W  = SLOT_W;

  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
  localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;
  localparam logic [63:0] KEY_MASK  =
    (KEY_BYTES >= 8) ? {64{1'b1}} : ((64'd1 << (8 * KEY_BYTES)) - 64'd1);

  typedef struct packed {
    logic [63:0]       key;
    logic              priced;
    logic [31:0]       price;
    logic [SLOT_W-1:0] slot;
  } item_t;

  typedef struct packed {
    logic             valid;
    logic [CLS_W-1:0] cls;
  } slot_entry_t;

  typedef struct packed {
    logic [15:0] members;
    logic        any_price;
    logic [31:0] best_price;
    logic [15:0] best_item;
  } stats_t;

  typedef struct packed {
    logic [9:0]  class_id;
    logic        new_class;
    logic        table_full;
    logic [15:0] member_total;
    logic        class_priced;
    logic [31:0] class_price;
    logic [15:0] cheapest_item;
  } result_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SLOT,
    ST_KEY
  } back_state_t;

  // low product bits depend only on low operand bits, so a narrow hash suffices
  function automatic logic [SLOT_W-1:0] fnv_slot(input logic [63:0] key);
    logic [HASH_W-1:0] h;
    h = FNV_BASIS[HASH_W-1:0];
    for (int i = 0; i < KEY_BYTES; i++) begin
      h = HASH_W'((h ^ HASH_W'(key[8*i +: 8])) * FNV_PRIME[HASH_W-1:0]);
    end
    return h[SLOT_W-1:0];
  endfunction

endpackage

FILE: hdl/hash_group_by_min_price_top.sv
// hash group-by with cheapest member per class
// input queue: drive item_key, priced, price and push; a beat is taken on a
//   clock edge with push high and full low
// result queue: while empty is low the ports show the oldest result; a beat
//   is taken on a clock edge with pop high and empty low
// one result per item, in input order
// a two-entry input queue feeds the probe sequencer, so items keep arriving
//   while a result waits to be popped
// path: a pushed beat can enter the sequencer on the next edge; the
//   result is written to the output register from ST_SLOT when the first
//   slot is empty, or from ST_KEY on a first-slot hit; each further probe
//   passes through ST_SLOT and ST_KEY again (slot read, then key read)
// the sequencer takes its next item only in ST_IDLE, after the result of
//   the last one is written
// reset: synchronous rst clears counters and starts a pass that writes all
//   2048 slot table entries empty; full stays high during that pass
// a stalled result holds the sequencer before its next item; the input
//   queue then fills and raises full
module hash_group_by_min_price_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [63:0] item_key,
  input  logic        priced,
  input  logic [31:0] price,
  output logic        empty,
  input  logic        pop,
  output logic [9:0]  class_id,
  output logic        new_class,
  output logic        table_full,
  output logic [15:0] member_total,
  output logic        class_priced,
  output logic [31:0] class_price,
  output logic [15:0] cheapest_item
);

  hgbm_pkg::item_t   q_item;
  hgbm_pkg::result_t res, res_q;
  logic q_valid;
  logic q_take;
  logic res_we;
  logic clearing;
  logic out_valid;
  logic out_free;

  // output register frees when empty or popped this cycle
  assign out_free = !out_valid || pop;
  assign empty    = !out_valid;

  hgbm_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .item_key(item_key), .priced(priced), .price(price),
    .busy(clearing), .q_valid(q_valid), .q_item(q_item), .q_take(q_take)
  );

  hgbm_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_item(q_item), .q_take(q_take),
    .out_free(out_free), .res_we(res_we), .res(res), .clearing(clearing)
  );

  // result holding register
  always_ff @(posedge clk) begin
    if (res_we) begin
      res_q <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_we) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign class_id      = res_q.class_id;
  assign new_class     = res_q.new_class;
  assign table_full    = res_q.table_full;
  assign member_total  = res_q.member_total;
  assign class_priced  = res_q.class_priced;
  assign class_price   = res_q.class_price;
  assign cheapest_item = res_q.cheapest_item;

  // a dropped item carries nothing else
  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && table_full) |-> (!new_class && member_total == 16'd0 && !class_priced))
    else $error("dropped item result not clean");

  // a freshly opened class has exactly one member
  a_new_one: assert property (@(posedge clk) disable iff (rst)
    (!empty && new_class) |-> (member_total == 16'd1))
    else $error("new class member count wrong");

  // no result is written over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_we |-> out_free)
    else $error("result overwritten");

  // no item is taken while the slot table is being cleared
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (full && !q_take))
    else $error("item taken during clear");

endmodule

FILE: hdl/hgbm_ram.sv
module hgbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/hgbm_front.sv
module hgbm_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic [63:0]   item_key,
  input  logic          priced,
  input  logic [31:0]   price,
  input  logic          busy,
  output logic          q_valid,
  output hgbm_pkg::item_t q_item,
  input  logic          q_take
);

  hgbm_pkg::item_t entries [2];
  hgbm_pkg::item_t in_item;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       accept;

  assign full    = busy || (count == 2'd2);
  assign accept  = push && !full;
  assign q_valid = (count != 2'd0);
  assign q_item  = entries[rd_ptr];

  always_comb begin
    in_item.key    = item_key & hgbm_pkg::KEY_MASK;
    in_item.priced = priced;
    in_item.price  = price;
    in_item.slot   = hgbm_pkg::fnv_slot(item_key & hgbm_pkg::KEY_MASK);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      entries[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_take) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(accept) - 2'(q_take);
    end
  end

endmodule

FILE: hdl/hgbm_back.sv
module hgbm_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  hgbm_pkg::item_t   q_item,
  output logic              q_take,
  input  logic              out_free,
  output logic              res_we,
  output hgbm_pkg::result_t res,
  output logic              clearing
);

  hgbm_pkg::back_state_t state, state_next;
  hgbm_pkg::item_t       cur, cur_next;
  logic [hgbm_pkg::SLOT_W-1:0]  clr_addr, clr_addr_next;
  logic [hgbm_pkg::SLOT_W-1:0]  slot_ptr, slot_ptr_next;
  logic [hgbm_pkg::PROBE_W-1:0] probes, probes_next;
  logic [hgbm_pkg::USED_W-1:0]  classes_used, classes_used_next;
  logic [hgbm_pkg::SEQ_W-1:0]   item_counter, item_counter_next;
  logic [hgbm_pkg::SEQ_W-1:0]   seq, seq_next;
  logic [hgbm_pkg::CLS_W-1:0]   cur_cls, cur_cls_next;

  logic                         slot_we;
  logic [hgbm_pkg::SLOT_W-1:0]  slot_waddr, slot_raddr;
  hgbm_pkg::slot_entry_t        slot_wdata, slot_rdata;
  logic                         cls_we;
  logic [hgbm_pkg::CLS_W-1:0]   cls_waddr, cls_raddr;
  logic [63:0]                  key_rdata;
  hgbm_pkg::stats_t             stats_wdata, stats_rdata, stats_base;
  logic [hgbm_pkg::CLS_W-1:0]   new_cls;

  hgbm_ram #(.WIDTH($bits(hgbm_pkg::slot_entry_t)), .DEPTH(hgbm_pkg::SLOT_COUNT)) u_slot_ram (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(slot_raddr), .rdata(slot_rdata)
  );

  hgbm_ram #(.WIDTH(64), .DEPTH(hgbm_pkg::CLASS_CAPACITY)) u_key_ram (
    .clk(clk), .we(cls_we), .waddr(cls_waddr), .wdata(cur.key),
    .raddr(cls_raddr), .rdata(key_rdata)
  );

  hgbm_ram #(.WIDTH($bits(hgbm_pkg::stats_t)), .DEPTH(hgbm_pkg::CLASS_CAPACITY)) u_stats_ram (
    .clk(clk), .we(cls_we), .waddr(cls_waddr), .wdata(stats_wdata),
    .raddr(cls_raddr), .rdata(stats_rdata)
  );

  assign clearing = (state == hgbm_pkg::ST_CLEAR);
  assign new_cls  = classes_used[hgbm_pkg::CLS_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= hgbm_pkg::ST_CLEAR;
      clr_addr     <= '0;
      classes_used <= '0;
      item_counter <= '0;
    end else begin
      state        <= state_next;
      clr_addr     <= clr_addr_next;
      classes_used <= classes_used_next;
      item_counter <= item_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    cur      <= cur_next;
    slot_ptr <= slot_ptr_next;
    probes   <= probes_next;
    seq      <= seq_next;
    cur_cls  <= cur_cls_next;
  end

  always_comb begin
    state_next        = state;
    cur_next          = cur;
    clr_addr_next     = clr_addr;
    slot_ptr_next     = slot_ptr;
    probes_next       = probes;
    classes_used_next = classes_used;
    item_counter_next = item_counter;
    seq_next          = seq;
    cur_cls_next      = cur_cls;
    q_take            = 1'b0;
    res_we            = 1'b0;
    res               = '0;
    slot_we           = 1'b0;
    slot_waddr        = slot_ptr;
    slot_wdata        = '0;
    slot_raddr        = slot_ptr;
    cls_we            = 1'b0;
    cls_waddr         = cur_cls;
    cls_raddr         = cur_cls;
    stats_base        = stats_rdata;

    unique case (state)
      hgbm_pkg::ST_CLEAR: begin
        slot_we       = 1'b1;
        slot_waddr    = clr_addr;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == {hgbm_pkg::SLOT_W{1'b1}}) begin
          state_next = hgbm_pkg::ST_IDLE;
        end
      end
      hgbm_pkg::ST_IDLE: begin
        if (q_valid && out_free) begin
          q_take            = 1'b1;
          cur_next          = q_item;
          slot_ptr_next     = q_item.slot;
          slot_raddr        = q_item.slot;
          probes_next       = '0;
          seq_next          = item_counter;
          item_counter_next = item_counter + 1'b1;
          state_next        = hgbm_pkg::ST_SLOT;
        end
      end
      hgbm_pkg::ST_SLOT: begin
        if (!slot_rdata.valid) begin
          res_we     = 1'b1;
          state_next = hgbm_pkg::ST_IDLE;
          if (classes_used >= hgbm_pkg::USED_W'(hgbm_pkg::CLASS_CAPACITY)) begin
            res.table_full = 1'b1;
          end else begin
            slot_we           = 1'b1;
            slot_wdata.valid  = 1'b1;
            slot_wdata.cls    = new_cls;
            cls_we            = 1'b1;
            cls_waddr         = new_cls;
            stats_base        = '0;
            res.new_class     = 1'b1;
            res.class_id      = 10'(new_cls);
            classes_used_next = classes_used + 1'b1;
          end
        end else begin
          cls_raddr    = slot_rdata.cls;
          cur_cls_next = slot_rdata.cls;
          state_next   = hgbm_pkg::ST_KEY;
        end
      end
      hgbm_pkg::ST_KEY: begin
        if (key_rdata == cur.key) begin
          res_we       = 1'b1;
          cls_we       = 1'b1;
          res.class_id = 10'(cur_cls);
          state_next   = hgbm_pkg::ST_IDLE;
        end else if (probes == hgbm_pkg::PROBE_W'(hgbm_pkg::SLOT_COUNT - 1)) begin
          res_we         = 1'b1;
          res.table_full = 1'b1;
          state_next     = hgbm_pkg::ST_IDLE;
        end else begin
          probes_next   = probes + 1'b1;
          slot_ptr_next = slot_ptr + 1'b1;
          slot_raddr    = slot_ptr + 1'b1;
          state_next    = hgbm_pkg::ST_SLOT;
        end
      end
      default: begin
        state_next = hgbm_pkg::ST_IDLE;
      end
    endcase

    // member count and cheapest price update, shared by join and open
    stats_wdata = stats_base;
    if (stats_base.members != 16'hffff) begin
      stats_wdata.members = stats_base.members + 16'd1;
    end
    if (cur.priced && (!stats_base.any_price || (cur.price < stats_base.best_price))) begin
      stats_wdata.any_price  = 1'b1;
      stats_wdata.best_price = cur.price;
      stats_wdata.best_item  = 16'(seq);
    end
    if (res_we && !res.table_full) begin
      res.member_total  = stats_wdata.members;
      res.class_priced  = stats_wdata.any_price;
      res.class_price   = stats_wdata.best_price;
      res.cheapest_item = stats_wdata.best_item;
    end
  end

endmodule
